// ===== src/cosd_pkg.sv =====
// Shared types, constants and width helpers for the cosine distance engine.
package cosd_pkg;

   localparam int DEF_MAX_LENGTH    = 1024;
   localparam int DEF_ELEMENT_WIDTH = 16;
   localparam int CFG_W             = 11;
   localparam int DIST_W            = 18;
   localparam int VNUM_W            = 16;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_ADDR_W        = 2;
   localparam int FRAC_W            = 16;

   localparam logic [CFG_W-1:0]  LENGTH_RESET = CFG_W'(128);
   localparam logic [DIST_W-1:0] ONE_Q16      = DIST_W'(65536);
   localparam logic [DIST_W-1:0] TWO_Q16      = DIST_W'(131072);

   typedef enum logic [0:0] {
      REG_VECTOR_LENGTH = 1'b0
   } reg_index_type;

   typedef enum logic [0:0] {
      KIND_QUERY    = 1'b0,
      KIND_DATABASE = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_QROOT,
      ST_VROOT,
      ST_DEN,
      ST_DIVGO,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic acc;
      logic qroot_take;
      logic vroot_take;
      logic den;
      logic div_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic last;
      logic sqrt_busy;
      logic div_busy;
      logic out_free;
   } sts_type;

   function automatic int sq_width(int ew, int ml);
      int w;
      w = 2 * ew - 1 + $clog2(ml);
      return (w > 64) ? 64 : w;
   endfunction

   function automatic int dot_width(int ew, int ml);
      int w;
      w = 2 * ew + $clog2(ml);
      return (w > 64) ? 64 : w;
   endfunction

   function automatic int num_width(int dw);
      return (dw + FRAC_W > 64) ? 64 : dw + FRAC_W;
   endfunction

endpackage

// ===== src/cosd_ifaces.sv =====
// Valid/ready channel interfaces for element transactions and distance results.
interface cosd_req_if #(parameter int ELEMENT_WIDTH = cosd_pkg::DEF_ELEMENT_WIDTH);
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [ELEMENT_WIDTH-1:0] element;
   modport source (output valid, kind, element, input ready);
   modport sink   (input valid, kind, element, output ready);
endinterface

interface cosd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cosd_pkg::DIST_W-1:0]   distance;
   logic [cosd_pkg::VNUM_W-1:0]   vector_number;
   modport source (output valid, distance, vector_number, input ready);
   modport sink   (input valid, distance, vector_number, output ready);
endinterface

// ===== src/cosd_sqrt.sv =====
// Iterative integer square root, two operand bits per cycle.
module cosd_sqrt #(
   parameter int W = 42
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   operand,
   output logic           busy,
   output logic [W/2-1:0] root
);
   localparam int HALF = W / 2;

   logic [W-1:0] x_ff, x_in, res_ff, res_in, bit_ff, bit_in, trial;
   logic         busy_ff, busy_in;

   always_comb begin
      trial   = res_ff + bit_ff;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = operand;
         res_in  = '0;
         bit_in  = W'(1) << (W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         busy_in = !bit_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[HALF-1:0];
endmodule

// ===== src/cosd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module cosd_div #(
   parameter int NW = 58,
   parameter int DW = 42
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numerator,
   input  logic [DW-1:0] denominator,
   output logic          busy,
   output logic [NW-1:0] quotient
);
   localparam int CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    num_ff, num_in;
   logic [DW-1:0]    den_ff, den_in, rem_ff, rem_in;
   logic [DW:0]      shifted;
   logic             qbit;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      shifted = {rem_ff, num_ff[NW-1]};
      qbit    = (shifted >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         num_in = numerator;
         den_in = denominator;
         rem_in = '0;
         cnt_in = CNT_W'(NW);
      end else if (cnt_ff != '0) begin
         rem_in = qbit ? DW'(shifted - {1'b0, den_ff}) : shifted[DW-1:0];
         num_in = {num_ff[NW-2:0], qbit};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = num_ff;
endmodule

// ===== src/cosd_ctrl.sv =====
// Sequencing state machine for accumulation, roots, divide and result hand-off.
module cosd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cosd_pkg::sts_type sts,
   output cosd_pkg::cmd_type cmd
);
   import cosd_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC: begin
            if (!sts.last) begin
               state_in = ST_IDLE;
            end else if (sts.kind == KIND_DATABASE) begin
               state_in = ST_VROOT;
            end else begin
               state_in = ST_QROOT;
            end
         end
         ST_QROOT: if (!sts.sqrt_busy) state_in = ST_IDLE;
         ST_VROOT: if (!sts.sqrt_busy) state_in = ST_DEN;
         ST_DEN:   state_in = ST_DIVGO;
         ST_DIVGO: state_in = ST_DIV;
         ST_DIV:   if (!sts.div_busy) state_in = ST_DONE;
         ST_DONE:  if (sts.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_ready      = (state_ff == ST_IDLE);
      cmd.load       = (state_ff == ST_IDLE) && req_valid;
      cmd.mul        = (state_ff == ST_MUL);
      cmd.acc        = (state_ff == ST_ACC);
      cmd.qroot_take = (state_ff == ST_QROOT) && !sts.sqrt_busy;
      cmd.vroot_take = (state_ff == ST_VROOT) && !sts.sqrt_busy;
      cmd.den        = (state_ff == ST_DEN);
      cmd.div_start  = (state_ff == ST_DIVGO);
      cmd.emit       = (state_ff == ST_DONE) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== src/cosd_datapath.sv =====
// Query store, multiply-accumulate, magnitudes, quotient and result register.
module cosd_datapath #(
   parameter int MAX_LENGTH    = cosd_pkg::DEF_MAX_LENGTH,
   parameter int ELEMENT_WIDTH = cosd_pkg::DEF_ELEMENT_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cosd_pkg::cmd_type             cmd,
   output cosd_pkg::sts_type             sts,
   input  logic [cosd_pkg::CFG_W-1:0]    vector_length,
   input  logic                          kind,
   input  logic [ELEMENT_WIDTH-1:0]      element,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cosd_pkg::DIST_W-1:0]   distance,
   output logic [cosd_pkg::VNUM_W-1:0]   vector_number
);
   import cosd_pkg::*;

   localparam int EW     = ELEMENT_WIDTH;
   localparam int IDX_W  = $clog2(MAX_LENGTH > 1 ? MAX_LENGTH : 2);
   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
   localparam int SQ_W   = sq_width(EW, MAX_LENGTH);
   localparam int DOT_W  = dot_width(EW, MAX_LENGTH);
   localparam int RT_W   = (SQ_W + 1) / 2;
   localparam int RIN_W  = 2 * RT_W;
   localparam int DEN_W  = 2 * RT_W;
   localparam int NUM_W  = num_width(DOT_W);

   logic [EW-1:0]   store [MAX_LENGTH];

   logic                kind_ff;
   logic [EW-1:0]       elem_ff, rd_ff;
   logic                rdv_ff;
   logic signed [2*EW-1:0] prod_ff, sq_ff;
   logic [IDX_W-1:0]    qidx_ff, eidx_ff;
   logic [LEN_W-1:0]    fill_ff;
   logic [SQ_W-1:0]     qsq_ff, vsq_ff, qsq_sum, vsq_sum, sq_ext;
   logic [DOT_W-1:0]    dot_ff, dot_sum, prod_ext, dotfin_ff, mag;
   logic [RT_W-1:0]     qmag_ff, vmag_ff, root;
   logic [DEN_W-1:0]    den_ff;
   logic [NUM_W-1:0]    num_ff, quotient;
   logic                neg_ff, zmag_ff;
   logic [VNUM_W-1:0]   vcount_ff;
   logic                rsp_valid_ff;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic [VNUM_W-1:0]   vnum_ff;
   logic [CMP_W-1:0]    len_raw, len, qnext, enext;
   logic                q_last, v_last, sqrt_busy, div_busy, big;
   logic [EW-1:0]       qe;
   logic [RIN_W-1:0]    root_in;

   always_comb begin
      len_raw = CMP_W'(vector_length);
      if (len_raw == '0) begin
         len = CMP_W'(1);
      end else if (len_raw > CMP_W'(MAX_LENGTH)) begin
         len = CMP_W'(MAX_LENGTH);
      end else begin
         len = len_raw;
      end
      qnext    = CMP_W'(qidx_ff) + CMP_W'(1);
      enext    = CMP_W'(eidx_ff) + CMP_W'(1);
      q_last   = (qnext >= len);
      v_last   = (enext >= len);
      qe       = rdv_ff ? rd_ff : '0;
      sq_ext   = SQ_W'(sq_ff[2*EW-2:0]);
      prod_ext = DOT_W'(prod_ff);
      qsq_sum  = ((qidx_ff == '0) ? '0 : qsq_ff) + sq_ext;
      vsq_sum  = vsq_ff + sq_ext;
      dot_sum  = dot_ff + prod_ext;
      root_in  = (kind_ff == KIND_DATABASE) ? RIN_W'(vsq_sum) : RIN_W'(qsq_sum);
      mag      = dotfin_ff[DOT_W-1] ? (~dotfin_ff + DOT_W'(1)) : dotfin_ff;
      big      = (quotient[NUM_W-1:FRAC_W] != '0);
      if (zmag_ff) begin
         dist_in = ONE_Q16;
      end else if (neg_ff) begin
         dist_in = big ? TWO_Q16 : ONE_Q16 + DIST_W'(quotient[FRAC_W-1:0]);
      end else begin
         dist_in = big ? '0 : ONE_Q16 - DIST_W'(quotient[FRAC_W-1:0]);
      end
   end

   assign sts.kind      = kind_ff;
   assign sts.last      = (kind_ff == KIND_DATABASE) ? v_last : q_last;
   assign sts.sqrt_busy = sqrt_busy;
   assign sts.div_busy  = div_busy;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   cosd_sqrt #(.W(RIN_W)) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.acc && sts.last),
      .operand (root_in),
      .busy    (sqrt_busy),
      .root    (root)
   );

   cosd_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .numerator   (num_ff),
      .denominator (den_ff),
      .busy        (div_busy),
      .quotient    (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.load && kind == KIND_QUERY) begin
         store[qidx_ff] <= element;
      end
      if (cmd.load) begin
         rd_ff   <= store[eidx_ff];
         rdv_ff  <= (LEN_W'(eidx_ff) < fill_ff);
         elem_ff <= element;
         kind_ff <= kind;
      end
      if (cmd.mul) begin
         prod_ff <= $signed(qe) * $signed(elem_ff);
         sq_ff   <= $signed(elem_ff) * $signed(elem_ff);
      end
      if (cmd.acc && kind_ff == KIND_DATABASE && v_last) begin
         dotfin_ff <= dot_sum;
      end
      if (cmd.vroot_take) begin
         vmag_ff <= root;
      end
      if (cmd.den) begin
         den_ff  <= qmag_ff * vmag_ff;
         zmag_ff <= (qmag_ff == '0) || (vmag_ff == '0);
         neg_ff  <= dotfin_ff[DOT_W-1];
         num_ff  <= NUM_W'({mag, {FRAC_W{1'b0}}});
      end
      if (cmd.emit) begin
         dist_ff <= dist_in;
         vnum_ff <= vcount_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qidx_ff      <= '0;
         eidx_ff      <= '0;
         fill_ff      <= '0;
         qsq_ff       <= '0;
         vsq_ff       <= '0;
         dot_ff       <= '0;
         qmag_ff      <= '0;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load && kind == KIND_QUERY && LEN_W'(qnext) > fill_ff) begin
            fill_ff <= LEN_W'(qnext);
         end
         if (cmd.acc) begin
            if (kind_ff == KIND_QUERY) begin
               eidx_ff <= '0;
               dot_ff  <= '0;
               vsq_ff  <= '0;
               qsq_ff  <= qsq_sum;
               if (q_last) begin
                  qidx_ff   <= '0;
                  vcount_ff <= '0;
               end else begin
                  qidx_ff <= qidx_ff + IDX_W'(1);
               end
            end else if (v_last) begin
               eidx_ff <= '0;
               dot_ff  <= '0;
               vsq_ff  <= '0;
            end else begin
               eidx_ff <= eidx_ff + IDX_W'(1);
               dot_ff  <= dot_sum;
               vsq_ff  <= vsq_sum;
            end
         end
         if (cmd.qroot_take) begin
            qmag_ff <= root;
         end
         if (cmd.emit) begin
            vcount_ff    <= vcount_ff + VNUM_W'(1);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign distance      = dist_ff;
   assign vector_number = vnum_ff;
endmodule

// ===== src/batch_cosine_distance_unit.sv =====
// Cosine distance engine top level: channels, length register, controller and datapath.
// Each element transaction runs store read, multiply and accumulate in turn, one in flight.
// The last query element then also runs the shared square root.
// The last database element adds the root, a magnitude product and a divide before the
// result registers; a still-waiting result holds it there.
// Reset is synchronous: it clears all sums, indices, the store fill count and sets length 128.
module batch_cosine_distance_unit #(
   parameter int MAX_LENGTH    = cosd_pkg::DEF_MAX_LENGTH,
   parameter int ELEMENT_WIDTH = cosd_pkg::DEF_ELEMENT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   cosd_req_if.sink                          req_ch,
   cosd_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cosd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cosd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cosd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import cosd_pkg::*;

   cmd_type            cmd;
   sts_type            sts;
   logic [CFG_W-1:0]   length_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == CSR_ADDR_W'({REG_VECTOR_LENGTH, 2'b00}));
   assign csr_prdata = CSR_DATA_W'(length_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_RESET;
      end else if (csr_wr) begin
         length_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   cosd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cosd_datapath #(
      .MAX_LENGTH    (MAX_LENGTH),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .vector_length (length_ff),
      .kind          (req_ch.kind),
      .element       (req_ch.element[ELEMENT_WIDTH-1:0]),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .distance      (rsp_ch.distance),
      .vector_number (rsp_ch.vector_number)
   );
endmodule

// ===== src/cosd_checker.sv =====
// Port-level assertions for the cosine distance engine and their binding.
module cosd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cosd_pkg::DIST_W-1:0]   distance,
   input logic [cosd_pkg::VNUM_W-1:0]   vector_number
);
   import cosd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(distance) && $stable(vector_number))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction accepted while previous still in flight");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> distance <= TWO_Q16)
      else $error("distance beyond saturation bound");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind batch_cosine_distance_unit cosd_checker u_cosd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .distance      (rsp_ch.distance),
   .vector_number (rsp_ch.vector_number)
);

// ===== sim/batch_cosine_distance_unit_tb.sv =====
// Self-checking testbench for the batch cosine distance unit.
module batch_cosine_distance_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cosd_pkg::*;

   localparam int MAXL = DEF_MAX_LENGTH;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic [VNUM_W-1:0] vector_number;
   } distance_result_type;

   class distance_scoreboard;
      logic [15:0]       query_mem [MAXL];
      int unsigned       vlen;
      int unsigned       qidx, eidx;
      longint unsigned   qsum, qmag, dsum, vsum;
      logic [15:0]       vcount;
      distance_result_type pending_distances[$];
      int                errors;

      function void clear();
         foreach (query_mem[i]) query_mem[i] = '0;
         vlen = 128; qidx = 0; eidx = 0; qsum = 0; qmag = 0;
         dsum = 0; vsum = 0; vcount = 0; errors = 0;
         pending_distances.delete();
      endfunction

      function longint unsigned int_root(longint unsigned x);
         longint unsigned r, b;
         r = 0; b = 64'd1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x -= r + b; r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function logic [DIST_W-1:0] cosine_dist(longint unsigned d, longint unsigned qm,
                                               longint unsigned vm);
         longint unsigned den, m, q;
         if (qm == 0 || vm == 0) return ONE_Q16;
         den = qm * vm;
         if (d[63]) begin
            m = ~d + 1; q = (m << 16) / den;
            return (q >= 65536) ? TWO_Q16 : DIST_W'(65536 + q);
         end
         q = (d << 16) / den;
         return (q >= 65536) ? '0 : DIST_W'(65536 - q);
      endfunction

      function void note_element(kind_type k, logic [15:0] el);
         int unsigned len;
         longint signed e, qe;
         distance_result_type r;
         len = (vlen == 0) ? 1 : (vlen > MAXL ? MAXL : vlen);
         e = longint'(signed'(el));
         if (k == KIND_QUERY) begin
            eidx = 0; dsum = 0; vsum = 0;
            if (qidx == 0) qsum = 0;
            if (qidx < MAXL) query_mem[qidx] = el;
            qsum += e * e;
            if (qidx + 1 >= len) begin
               qmag = int_root(qsum); qidx = 0; vcount = 0;
            end else begin
               qidx++;
            end
            return;
         end
         qe = (eidx < MAXL) ? longint'(signed'(query_mem[eidx])) : 0;
         dsum += qe * e;
         vsum += e * e;
         if (eidx + 1 < len) begin
            eidx++;
            return;
         end
         r.distance = cosine_dist(dsum, qmag, int_root(vsum));
         r.vector_number = vcount;
         pending_distances.push_back(r);
         vcount++; eidx = 0; dsum = 0; vsum = 0;
      endfunction

      task check_result(logic [DIST_W-1:0] d, logic [VNUM_W-1:0] n);
         distance_result_type x;
         if (pending_distances.size() == 0) begin
            report_mismatch($sformatf("unexpected result dist=%0d num=%0d", d, n));
            return;
         end
         x = pending_distances.pop_front();
         if (d !== x.distance)
            report_mismatch($sformatf("distance %0d, want %0d", d, x.distance));
         if (n !== x.vector_number)
            report_mismatch($sformatf("vector_number %0d, want %0d", n, x.vector_number));
      endtask

      task report_mismatch(string s);
         $display("mismatch: %s", s);
         errors++;
      endtask
   endclass

   logic clock, reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   bit   idle_enable, hold_rsp, held;

   cosd_req_if req_ch ();
   cosd_rsp_if rsp_ch ();
   distance_scoreboard distances = new();

   batch_cosine_distance_unit dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         distances.note_element(kind_type'(req_ch.kind), req_ch.element);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         distances.check_result(rsp_ch.distance, rsp_ch.vector_number);
   end

   // receiver: random stalls, one long hold
   initial begin
      int n;
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 0;
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            rsp_ch.ready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic write_length(logic [CSR_DATA_W-1:0] v);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CSR_ADDR_W'(4 * REG_VECTOR_LENGTH); csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      distances.vlen = v[CFG_W-1:0];
      @(posedge clock);
   endtask

   task automatic send_element(kind_type k, logic [15:0] el);
      int n;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 10);
         req_ch.valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_ch.valid <= 1; req_ch.kind <= k; req_ch.element <= el;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (distances.pending_distances.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_element();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_vector(kind_type k, int len, int mode);
      for (int i = 0; i < len; i++)
         send_element(k, mode == 1 ? 16'h7fff : (mode == 2 ? 16'h8000 :
                      (mode == 3 ? 16'h0000 : rand_element())));
   endtask

   initial begin
      int len, sent;
      distances.clear();
      reset = 1;
      req_ch.valid = 0; req_ch.kind = 0; req_ch.element = '0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      idle_enable = 0; hold_rsp = 0; held = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: no query yet, then extremes with a short length
      write_length(0);
      send_vector(KIND_DATABASE, 1, 1);
      drain();
      write_length(4);
      send_vector(KIND_QUERY, 4, 1);
      send_vector(KIND_DATABASE, 4, 1);
      send_vector(KIND_DATABASE, 4, 2);
      send_vector(KIND_DATABASE, 4, 3);
      send_element(KIND_DATABASE, 16'h1234);
      send_element(KIND_QUERY, 16'h4000);
      send_element(KIND_DATABASE, 16'h4000);
      send_vector(KIND_QUERY, 3, 0);
      send_vector(KIND_DATABASE, 4, 0);
      drain();
      write_length(2000);
      drain();
      write_length(2);
      sent = 0;
      idle_enable = 1;
      while (sent < 1800) begin
         if (sent > 600 && !held) begin
            hold_rsp = 1; held = 1;
         end
         if (sent > 1500) idle_enable = 0;
         if (idle_enable && $urandom_range(0, 9) == 0) begin
            drain();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
            write_length(len);
            len = (len == 0) ? 1 : len;
            send_vector(KIND_QUERY, len, 0);
            sent += len;
         end else begin
            len = (distances.vlen == 0) ? 1 : distances.vlen;
            if ($urandom_range(0, 15) == 0) len = $urandom_range(1, len);
            send_vector(($urandom_range(0, 12) == 0) ? KIND_QUERY : KIND_DATABASE,
                        len, ($urandom_range(0, 20) == 0) ? $urandom_range(1, 3) : 0);
            sent += len;
         end
      end
      drain();
      write_length(11'h7ff);
      drain();
      if (distances.errors == 0 && distances.pending_distances.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
